// File: design/kld_pkg.sv
// ----------------------------------------------------------------------------
// kld_pkg
// Shared types, ladder tables and key codes for the ladder key decoder.
// ----------------------------------------------------------------------------
package kld_pkg;

    // Number of ladder entries searched per sample (2..16).
    localparam int LADDER_STEPS = 6;
    localparam int TAB_DEPTH    = 16;

    localparam logic [2:0] KEY_NONE    = 3'd0;
    localparam logic [2:0] KEY_CLEAR   = 3'd3;
    localparam logic [2:0] KEY_COMPND  = 3'd4;
    localparam logic [1:0] COUNT_MAX   = 2'd3;

    localparam logic LADDER_SET0 = 1'b0;
    localparam logic LADDER_SET1 = 1'b1;

    // Thresholds, highest first; unused entries sit at full scale.
    localparam logic [7:0] THR_TAB [0:1][0:TAB_DEPTH-1] = '{
        '{8'd92, 8'd72, 8'd52, 8'd33, 8'd12, 8'd0,
          8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
          8'd255, 8'd255, 8'd255, 8'd255},
        '{8'd190, 8'd164, 8'd148, 8'd134, 8'd120, 8'd106,
          8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
          8'd255, 8'd255, 8'd255, 8'd255}
    };

    localparam logic [2:0] CODE_TAB [0:1][0:TAB_DEPTH-1] = '{
        '{3'd0, 3'd3, 3'd1, 3'd2, 3'd0, 3'd4,
          3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0,
          3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
    };

    localparam logic [7:0] RELEASE_TAB [0:1] = '{8'd92, 8'd190};

    // Classification of one sample against the selected ladder.
    typedef struct packed {
        logic       release_hit;
        logic       step_hit;
        logic [2:0] code;
    } t_class;

    // One result beat.
    typedef struct packed {
        logic [2:0] key_code;
        logic       key_fault;
        logic       locked;
        logic       clear_error;
    } t_result;

endpackage

// File: design/kld_classify.sv
// ----------------------------------------------------------------------------
// kld_classify
// Compare one sample against the selected ladder and pick the first step hit.
// ----------------------------------------------------------------------------
module kld_classify (
    input  logic            i_ladder_select,
    input  logic [7:0]      i_sample,
    output kld_pkg::t_class o_class
);
    import kld_pkg::*;

    always_comb begin
        o_class.release_hit = (i_sample >= RELEASE_TAB[i_ladder_select]);
        o_class.step_hit    = 1'b0;
        o_class.code        = KEY_NONE;
        // Walk from the last step back so the first matching step wins.
        for (int i = LADDER_STEPS - 1; i >= 0; i--) begin
            if (i_sample >= THR_TAB[i_ladder_select][4'(i)]) begin
                o_class.step_hit = 1'b1;
                o_class.code     = CODE_TAB[i_ladder_select][4'(i)];
            end
        end
    end

endmodule

// File: design/kld_tracker.sv
// ----------------------------------------------------------------------------
// kld_tracker
// Debounce, compound count, fault lock and key state; one update per beat.
// ----------------------------------------------------------------------------
module kld_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_hold_off,
    input  kld_pkg::t_class  i_class,
    output kld_pkg::t_result o_result
);
    import kld_pkg::*;

    logic [2:0] r_pending, n_pending;
    logic [2:0] r_current, n_current;
    logic [2:0] r_previous, n_previous;
    logic       r_fault, n_fault;
    logic       r_lock, n_lock;
    logic [1:0] r_count, n_count;
    logic       pulse;
    logic [2:0] cand;

    always_comb begin
        n_pending  = r_pending;
        n_current  = r_current;
        n_previous = r_previous;
        n_fault    = r_fault;
        n_lock     = r_lock;
        n_count    = r_count;
        pulse      = 1'b0;
        cand       = r_current;
        priority if (i_hold_off) begin
            // hold everything
        end else if (i_class.release_hit) begin
            n_lock     = 1'b0;
            n_previous = KEY_NONE;
            n_current  = KEY_NONE;
            n_fault    = 1'b0;
            n_pending  = KEY_NONE;
        end else if (r_lock || !i_class.step_hit) begin
            // hold while locked or below the lowest step
        end else if (r_pending != i_class.code) begin
            n_pending = i_class.code;
        end else begin
            if (i_class.code == KEY_CLEAR || i_class.code == KEY_COMPND) begin
                if (r_count == COUNT_MAX) begin
                    cand  = i_class.code;
                    pulse = (i_class.code == KEY_CLEAR);
                end else begin
                    n_count = r_count + 2'd1;
                end
            end else begin
                n_count = '0;
                cand    = i_class.code;
            end
            if (r_previous != KEY_NONE && r_previous != cand) begin
                n_lock    = 1'b1;
                n_fault   = 1'b1;
                n_current = KEY_NONE;
            end else begin
                n_previous = cand;
                n_current  = cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= KEY_NONE;
            r_current  <= KEY_NONE;
            r_previous <= KEY_NONE;
            r_fault    <= 1'b0;
            r_lock     <= 1'b0;
            r_count    <= '0;
        end else if (i_fire) begin
            r_pending  <= n_pending;
            r_current  <= n_current;
            r_previous <= n_previous;
            r_fault    <= n_fault;
            r_lock     <= n_lock;
            r_count    <= n_count;
        end
    end

    assign o_result.key_code    = n_fault ? KEY_NONE : n_current;
    assign o_result.key_fault   = n_fault;
    assign o_result.locked      = n_lock;
    assign o_result.clear_error = pulse;

endmodule

// File: design/adc_ladder_key_decoder_core.sv
// ----------------------------------------------------------------------------
// adc_ladder_key_decoder_core
// Resistor-ladder keypad decoder for 8-bit ADC samples.
// ----------------------------------------------------------------------------
// Each input beat carries one ADC sample and a hold-off flag; each beat
// produces exactly one result beat with the confirmed key code (0 = none),
// a fault flag, the lock flag and a one-beat clear_error pulse. A sample at
// or above the release level of the selected ladder (92 for set 0, 190 for
// set 1) clears the lock and the key state. Otherwise the first ladder step
// the sample reaches gives a raw code; it must repeat on two beats in a row,
// and codes 3 and 4 must also outlast a saturating compound count. A
// confirmed key that differs from an earlier nonzero key locks the block
// with key_fault set until release. Throughput is one beat per cycle while
// the result channel is not stalled. A beat passes through the input
// register, then the ladder compare and state update run into the result
// register. The key state loop closes within the state update, so
// consecutive beats see each other's updates. Write ladder_select
// through i_cfg_we / i_cfg_data only while no beat is in flight.
// ----------------------------------------------------------------------------
module adc_ladder_key_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    // sample channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_sample,
    input  logic       i_hold_off,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_key_code,
    output logic       o_key_fault,
    output logic       o_locked,
    output logic       o_clear_error
);
    import kld_pkg::*;

    logic       r_ladder_select;
    logic       r_in_valid;
    logic [7:0] r_sample;
    logic       r_hold_off;
    logic       r_out_valid;
    t_result    r_result;

    logic       out_busy;
    logic       fire;
    logic       in_load;
    t_class     cls;
    t_result    result;

    // Ladder select register; no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ladder_select <= LADDER_SET0;
        end else if (i_cfg_we) begin
            r_ladder_select <= i_cfg_data;
        end
    end

    // Result register is full and the consumer is stalling it.
    assign out_busy = r_out_valid && i_out_stall;
    // Advance the held sample into the state update when the result slot frees.
    assign fire     = r_in_valid && !out_busy;
    // Stall the sample channel only when the input register cannot drain.
    assign o_in_stall = r_in_valid && out_busy;
    assign in_load    = !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_sample   <= i_sample;
            r_hold_off <= i_hold_off;
        end
    end

    kld_classify u_classify (
        .i_ladder_select (r_ladder_select),
        .i_sample        (r_sample),
        .o_class         (cls)
    );

    kld_tracker u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_hold_off (r_hold_off),
        .i_class    (cls),
        .o_result   (result)
    );

    // Result register: load a fresh beat, drop the old one once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_busy) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_code    = r_result.key_code;
    assign o_key_fault   = r_result.key_fault;
    assign o_locked      = r_result.locked;
    assign o_clear_error = r_result.clear_error;

endmodule
